FILE: rtl/ib32_pkg.sv
`timescale 1ns / 1ps

package ib32_pkg;

    localparam int BLOCK_BYTES     = 5;
    localparam int CHARS_PER_BLOCK = 8;
    localparam int CHAR_W          = 7;
    localparam int GROUP_W         = 5;
    localparam int HALF_BITS       = 20;
    localparam int IDX_W           = 3;
    localparam int COUNT_W         = 3;

    localparam logic [7:0]         PAD_FIRST   = 8'h80;
    localparam logic [COUNT_W-1:0] COUNT_FULL  = 3'd4;
    localparam logic [IDX_W-1:0]   IDX_LAST    = 3'd7;
    localparam logic [4:0]         ALPHA_LIMIT = 5'd26;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
        logic              stream_done;
    } out_item_t;

    // Map a 5-bit group to its character: a-z, then 0-5.
    function automatic logic [CHAR_W-1:0] enc_char(input logic [GROUP_W-1:0] v);
        logic [CHAR_W-1:0] ch;
        if (v < ALPHA_LIMIT) begin
            ch = 7'h61 + {2'b00, v};
        end else begin
            ch = 7'h30 + {2'b00, v - ALPHA_LIMIT};
        end
        return ch;
    endfunction

endpackage

FILE: rtl/interleaved_base32_encoder.sv
`timescale 1ns / 1ps

// Interleaved base32 encoder.
// Input channel (s_valid/s_ready/s_data) takes one byte per item, with
// end_of_stream marking the final byte. Bytes gather into 5-byte blocks;
// an incomplete final block is padded with 0x80 and then zeros.
// Result channel (m_valid/m_ready/m_data) gives 8 characters per block,
// alternating 5 even bits and 5 odd bits, out_last on the eighth and
// stream_done on the eighth of the block that ends the stream.
// The first character is registered and valid in the cycle after the byte
// that completes the block is accepted; the rest follow one per cycle while
// the receiver is ready. Throughput: one byte per cycle is taken while a
// block is gathering; the eight-character output shift register sets the
// sustained rate. The byte that closes a block is held off only while the
// previous block still has characters to deliver, and is taken in the same
// cycle its eighth character goes out.
// When the receiver stalls, the current character holds; gathering goes on
// until the next block is ready to load.
// Reset clears the gathered bytes, the byte count and the output valid.
module interleaved_base32_encoder
    import ib32_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [31:0]                       held_reg, held_next;
    logic [COUNT_W-1:0]                count_reg, count_next;
    logic [CHARS_PER_BLOCK*CHAR_W-1:0] chars_reg, chars_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic                              busy_reg, busy_next;
    logic                              eos_reg, eos_next;

    logic                              completes;
    logic                              free_now;
    logic                              s_fire;
    logic                              load;
    logic [8*BLOCK_BYTES-1:0]          blk;
    logic [HALF_BITS-1:0]              ev;
    logic [HALF_BITS-1:0]              od;
    logic [CHARS_PER_BLOCK*CHAR_W-1:0] enc;

    assign completes = (count_reg >= COUNT_FULL) || s_data.end_of_stream;
    assign free_now  = !busy_reg || (m_ready && idx_reg == IDX_LAST);
    assign s_ready   = !completes || free_now;
    assign s_fire    = s_valid && s_ready;
    assign load      = s_fire && completes;

    // Assemble the block, oldest byte in the top byte, padding after the new one.
    always_comb begin
        case (count_reg)
            3'd0:    blk = {s_data.data_byte, PAD_FIRST, 24'h0};
            3'd1:    blk = {held_reg[7:0], s_data.data_byte, PAD_FIRST, 16'h0};
            3'd2:    blk = {held_reg[15:0], s_data.data_byte, PAD_FIRST, 8'h0};
            3'd3:    blk = {held_reg[23:0], s_data.data_byte, PAD_FIRST};
            default: blk = {held_reg, s_data.data_byte};
        endcase
    end

    // Split every byte into its even and odd MSB-first bit positions.
    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            for (int k = 0; k < 4; k++) begin
                ev[HALF_BITS-1-(4*i+k)] = blk[8*BLOCK_BYTES-1-8*i-2*k];
                od[HALF_BITS-1-(4*i+k)] = blk[8*BLOCK_BYTES-2-8*i-2*k];
            end
        end
    end

    // First character goes in the top slot of the shift register.
    always_comb begin
        for (int j = 0; j < CHARS_PER_BLOCK / 2; j++) begin
            enc[CHARS_PER_BLOCK*CHAR_W-1-(2*j)*CHAR_W -: CHAR_W] =
                enc_char(ev[HALF_BITS-1-GROUP_W*j -: GROUP_W]);
            enc[CHARS_PER_BLOCK*CHAR_W-1-(2*j+1)*CHAR_W -: CHAR_W] =
                enc_char(od[HALF_BITS-1-GROUP_W*j -: GROUP_W]);
        end
    end

    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        if (s_fire) begin
            if (completes) begin
                held_next  = '0;
                count_next = '0;
            end else begin
                held_next  = {held_reg[23:0], s_data.data_byte};
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_comb begin
        chars_next = chars_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        eos_next   = eos_reg;
        if (load) begin
            chars_next = enc;
            idx_next   = '0;
            busy_next  = 1'b1;
            eos_next   = s_data.end_of_stream;
        end else if (busy_reg && m_ready) begin
            if (idx_reg == IDX_LAST) begin
                busy_next = 1'b0;
            end else begin
                chars_next = {chars_reg[(CHARS_PER_BLOCK-1)*CHAR_W-1:0], {CHAR_W{1'b0}}};
                idx_next   = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            eos_reg   <= 1'b0;
        end else begin
            held_reg  <= held_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            eos_reg   <= eos_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
    end

    assign m_valid             = busy_reg;
    assign m_data.out_char     = chars_reg[CHARS_PER_BLOCK*CHAR_W-1 -: CHAR_W];
    assign m_data.out_last     = (idx_reg == IDX_LAST);
    assign m_data.stream_done  = eos_reg && (idx_reg == IDX_LAST);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("byte count above a full block");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && completes) |-> free_now)
        else $error("block loaded over undelivered characters");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stream_done) |-> m_data.out_last)
        else $error("stream_done without out_last");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.out_last && !(s_valid && s_ready && completes))
        |=> !m_valid)
        else $error("output stays valid after the eighth character");

    a_gather_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && completes) |=> (count_reg == '0 && m_valid && idx_reg == '0))
        else $error("block completion did not restart gathering");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ib32_pkg::*;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_SPARSE,
        RX_HEAVY
    } rx_mode_t;

    localparam int DIRECTED_STREAMS = 6;
    localparam int DIRECTED_BYTES   = 21;
    localparam int RANDOM_BYTES     = 135;
    localparam int HOLD_AFTER_BYTES = 60;
    localparam int HOLD_CYCLES      = 100;
    localparam int MAX_REPORTS      = 10;

    // Tracks the open block and the characters still owed by the encoder.
    class ib32_scoreboard;
        logic [31:0]  gathered;
        int unsigned  gathered_count;
        out_item_t    owed_chars[$];
        int unsigned  bytes_taken;
        int unsigned  chars_seen;
        int unsigned  mismatches;

        function new();
            gathered       = '0;
            gathered_count = 0;
            bytes_taken    = 0;
            chars_seen     = 0;
            mismatches     = 0;
        endfunction

        function logic [CHAR_W-1:0] glyph(input logic [4:0] v);
            if (v < 5'd26) begin
                return 7'd97 + {2'b00, v};
            end
            return 7'd48 + {2'b00, v - 5'd26};
        endfunction

        function void note_byte(input in_item_t it);
            logic [7:0]  blk[BLOCK_BYTES];
            logic [19:0] even_bits;
            logic [19:0] odd_bits;
            logic [4:0]  grp;
            out_item_t   ch;
            int unsigned n;

            bytes_taken++;
            n = (gathered_count > 4) ? 4 : gathered_count;
            if (n < 4 && !it.end_of_stream) begin
                gathered       = {gathered[23:0], it.data_byte};
                gathered_count = n + 1;
                return;
            end
            for (int i = 0; i < n; i++) begin
                blk[i] = 8'(gathered >> (8 * (n - 1 - i)));
            end
            blk[n] = it.data_byte;
            for (int i = n + 1; i < BLOCK_BYTES; i++) begin
                blk[i] = (i == n + 1) ? 8'h80 : 8'h00;
            end
            even_bits = '0;
            odd_bits  = '0;
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                even_bits = {even_bits[15:0], blk[i][7], blk[i][5], blk[i][3], blk[i][1]};
                odd_bits  = {odd_bits[15:0],  blk[i][6], blk[i][4], blk[i][2], blk[i][0]};
            end
            for (int i = 0; i < CHARS_PER_BLOCK; i++) begin
                grp = (i % 2) ? odd_bits[19 - 5 * (i / 2) -: 5]
                              : even_bits[19 - 5 * (i / 2) -: 5];
                ch.out_char    = glyph(grp);
                ch.out_last    = (i == CHARS_PER_BLOCK - 1);
                ch.stream_done = (i == CHARS_PER_BLOCK - 1) && it.end_of_stream;
                owed_chars.push_back(ch);
            end
            gathered       = '0;
            gathered_count = 0;
        endfunction

        function void check_char(input out_item_t got);
            out_item_t want;

            chars_seen++;
            if (owed_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("char %0d: unexpected, got char=%h last=%b done=%b",
                             chars_seen, got.out_char, got.out_last, got.stream_done);
                end
                return;
            end
            want = owed_chars.pop_front();
            if (got.out_char !== want.out_char || got.out_last !== want.out_last
                    || got.stream_done !== want.stream_done) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"char %0d: expected char=%h last=%b done=%b, ",
                              "got char=%h last=%b done=%b"},
                             chars_seen, want.out_char, want.out_last, want.stream_done,
                             got.out_char, got.out_last, got.stream_done);
                end
            end
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic      hold_off   = 1'b0;
    rx_mode_t  rx_mode    = RX_FREE;
    int        mode_left  = 0;
    int        burst_left = 0;

    ib32_scoreboard sb = new();

    interleaved_base32_encoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_byte(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_char(m_data);
            end
        end
    end

    // Receiver stall pattern: switch between free, sparse and heavy stalling.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 2));
            mode_left <= $urandom_range(20, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_FREE:   m_ready <= !hold_off;
            RX_SPARSE: m_ready <= !hold_off && ($urandom_range(0, 3) != 0);
            default:   m_ready <= !hold_off && ($urandom_range(0, 1) == 1);
        endcase
    end

    // Long receiver hold-off while the sender keeps offering bytes.
    initial begin
        while (sb.bytes_taken < HOLD_AFTER_BYTES) begin
            @(posedge aclk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Offer one byte and wait for it to be taken; drop valid only at the end of a burst.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        in_item_t it;

        it.data_byte     = b;
        it.end_of_stream = eos;
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic send_random_stream(input int len);
        logic [7:0] b;

        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hff;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, k == len - 1);
        end
    endtask

    initial begin
        logic [7:0] dir_bytes[DIRECTED_BYTES];
        int         dir_lens[DIRECTED_STREAMS];
        int         idx;
        int         sent;
        int         len;
        int         drain;

        dir_bytes = '{8'h00,
                      8'hff, 8'hff,
                      8'haa, 8'h55, 8'h0f,
                      8'hf0, 8'hcc, 8'h33, 8'h81,
                      8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                      8'h80, 8'h40, 8'h20, 8'h7f, 8'hfe, 8'h5a};
        dir_lens  = '{1, 2, 3, 4, 5, 6};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one stream of each tail length, plus an exact block and a block-plus-one.
        idx = 0;
        for (int s = 0; s < DIRECTED_STREAMS; s++) begin
            for (int k = 0; k < dir_lens[s]; k++) begin
                send_byte(dir_bytes[idx], k == dir_lens[s] - 1);
                idx++;
            end
        end

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30)
                                              : $urandom_range(1, 12);
            send_random_stream(len);
            sent += len;
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        drain = 20;
        repeat (drain) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("interleaved_base32_encoder: match");
        end else begin
            $display("interleaved_base32_encoder: mismatch");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("interleaved_base32_encoder: mismatch");
        $finish;
    end

endmodule
